// File: rtl/mdks_pkg.sv
// Shared types, constants and register indexes of the motor drive kick-start block.
package mdks_pkg;

	// Field widths
	localparam int unsigned LEVEL_W = 11;
	localparam int unsigned DUTY_W  = 10;
	localparam int unsigned MIN_W   = 10;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Drive scaling: duty = trunc(mag * DUTY_MAX / LEVEL_FULL)
	localparam int unsigned DUTY_MAX   = 1023;
	localparam int unsigned LEVEL_FULL = 1000;
	localparam int unsigned DUTY_SAT   = 1023;
	// DUTY_MAX / LEVEL_FULL in steps of 2^-RECIP_SHIFT, rounded up; the rounding error
	// stays below 1 / LEVEL_FULL for every magnitude up to LEVEL_FULL, so the floor is exact
	localparam int unsigned     RECIP_SHIFT = 20;
	localparam longint unsigned DUTY_RECIP  =
		((64'(DUTY_MAX) << RECIP_SHIFT) + 64'(LEVEL_FULL) - 64'd1) / 64'(LEVEL_FULL);

	// Register reset values
	localparam int unsigned MIN_START_RST   = 230;
	localparam int unsigned BOOST_DELAY_RST = 1000;

	typedef logic signed [LEVEL_W-1:0] level_t;
	typedef logic [DUTY_W-1:0]         duty_t;
	typedef logic [MIN_W-1:0]          min_lvl_t;
	typedef logic [DELAY_W-1:0]        delay_t;
	typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

	// Request opcodes
	typedef enum logic {
		OP_SET_LEVEL = 1'b0,
		OP_TICK      = 1'b1
	} opcode_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_START   = 2'd0,
		REG_BOOST_DELAY = 2'd1
	} cfg_idx_t;

	// Bridge direction: bit 0 forward, bit 1 reverse
	typedef enum logic [1:0] {
		DIR_OFF = 2'b00,
		DIR_FWD = 2'b01,
		DIR_REV = 2'b10
	} dir_t;

	// Drive state reported after each request
	typedef struct packed {
		duty_t duty;
		logic  drive_forward;
		logic  drive_reverse;
		logic  kicking;
	} drive_t;

endpackage

// File: rtl/mdks_if.sv
// Channel interfaces of the motor drive kick-start block: command, result and configuration.
interface mdks_cmd_if;
	logic                valid;
	logic                ready;
	mdks_pkg::opcode_t   opcode;
	mdks_pkg::level_t    level;

	modport source (output valid, output opcode, output level, input ready);
	modport sink   (input valid, input opcode, input level, output ready);
endinterface

interface mdks_res_if;
	logic                valid;
	logic                ready;
	mdks_pkg::duty_t     duty;
	logic                drive_forward;
	logic                drive_reverse;
	logic                kicking;

	modport source (output valid, output duty, output drive_forward, output drive_reverse,
		output kicking, input ready);
	modport sink   (input valid, input duty, input drive_forward, input drive_reverse,
		input kicking, output ready);
endinterface

interface mdks_cfg_if;
	logic                  valid;
	logic                  ready;
	mdks_pkg::cfg_idx_t    index;
	mdks_pkg::cfg_data_t   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/mdks_duty.sv
// Level magnitude to PWM compare value scaling.
module mdks_duty (
	input  logic [mdks_pkg::MIN_W-1:0] mag,
	output mdks_pkg::duty_t            duty
);
	import mdks_pkg::*;

	localparam int unsigned PROD_W = 40;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] scaled;

	// Scale by the reciprocal, then saturate to the compare range
	always_comb begin
		prod   = PROD_W'(mag) * PROD_W'(DUTY_RECIP);
		scaled = prod >> RECIP_SHIFT;
		if (scaled > PROD_W'(DUTY_SAT)) begin
			duty = DUTY_W'(DUTY_SAT);
		end else begin
			duty = scaled[DUTY_W-1:0];
		end
	end

endmodule

// File: rtl/mdks_core.sv
// Drive state registers with kick-start and boost countdown update logic.
module mdks_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  mdks_pkg::opcode_t    opcode,
	input  mdks_pkg::level_t     level,
	input  mdks_pkg::min_lvl_t   min_start,
	input  mdks_pkg::delay_t     boost_delay,
	output mdks_pkg::drive_t     drive_next
);
	import mdks_pkg::*;

	logic     stalled_q;
	level_t   pending_q;
	delay_t   count_q;
	logic     active_q;
	duty_t    duty_q;
	dir_t     dir_q;

	logic     stalled_d;
	level_t   pending_d;
	delay_t   count_d;
	logic     active_d;
	duty_t    duty_d;
	dir_t     dir_d;

	delay_t         count_dec;
	logic           do_drive;
	level_t         lv;
	logic [LEVEL_W-1:0] abs_lv;
	min_lvl_t       mag_req;
	min_lvl_t       mag_kick;
	min_lvl_t       mag;
	logic           kick;
	duty_t          duty_calc;

	// Pick the level to apply: new command or expiring boost
	always_comb begin
		count_dec = count_q - DELAY_W'(1);
		do_drive  = (opcode == OP_SET_LEVEL) || (active_q && (count_dec == '0));
		lv        = (opcode == OP_SET_LEVEL) ? level : pending_q;
		abs_lv    = lv[LEVEL_W-1] ? LEVEL_W'(-lv) : LEVEL_W'(lv);
		if (abs_lv > LEVEL_W'(LEVEL_FULL)) begin
			mag_req = MIN_W'(LEVEL_FULL);
		end else begin
			mag_req = abs_lv[MIN_W-1:0];
		end
		if (min_start > MIN_W'(LEVEL_FULL)) begin
			mag_kick = MIN_W'(LEVEL_FULL);
		end else begin
			mag_kick = min_start;
		end
		kick = stalled_q && (mag_req < min_start);
		mag  = kick ? mag_kick : mag_req;
	end

	mdks_duty u_duty (
		.mag  (mag),
		.duty (duty_calc)
	);

	// Next drive state for the request under way
	always_comb begin
		stalled_d = stalled_q;
		pending_d = pending_q;
		count_d   = count_q;
		active_d  = active_q;
		duty_d    = duty_q;
		dir_d     = dir_q;
		if (do_drive) begin
			// any drive starts with the pending boost cancelled
			active_d = 1'b0;
			count_d  = '0;
			if (lv == '0) begin
				duty_d    = '0;
				dir_d     = DIR_OFF;
				stalled_d = 1'b1;
			end else begin
				if (kick) begin
					pending_d = lv;
					stalled_d = 1'b0;
					active_d  = 1'b1;
					count_d   = (boost_delay == '0) ? DELAY_W'(1) : boost_delay;
				end
				duty_d = duty_calc;
				dir_d  = lv[LEVEL_W-1] ? DIR_REV : DIR_FWD;
			end
		end else if (active_q) begin
			count_d = count_dec;
		end
	end

	// Advance the state when the request moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stalled_q <= 1'b1;
			pending_q <= '0;
			count_q   <= '0;
			active_q  <= 1'b0;
			duty_q    <= '0;
			dir_q     <= DIR_OFF;
		end else if (advance) begin
			stalled_q <= stalled_d;
			pending_q <= pending_d;
			count_q   <= count_d;
			active_q  <= active_d;
			duty_q    <= duty_d;
			dir_q     <= dir_d;
		end
	end

	assign drive_next = '{
		duty:          duty_d,
		drive_forward: dir_d[0],
		drive_reverse: dir_d[1],
		kicking:       active_d
	};

endmodule

// File: rtl/motor_drive_kick_start_top.sv
// Top level of the motor drive kick-start block: request register, result register, config.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------------
//  cmd     | in  | valid / ready | opcode, level
//  res     | out | valid / ready | duty, drive_forward, drive_reverse, kicking
//  cfg     | in  | valid / ready | index, data (always ready)
//
// One request per cycle while res is not stalled; each result passes the request register
// and then the result register around the state update before it is presented on res.
// Reset: min_start_level 230, boost_delay_ticks 1000, motor stalled, bridge off.
// A stalled result register holds; the request register refills once it drains.
module motor_drive_kick_start_top (
	input  logic        clk,
	input  logic        arst_n,
	mdks_cmd_if.sink    cmd,
	mdks_res_if.source  res,
	mdks_cfg_if.sink    cfg
);
	import mdks_pkg::*;

	logic       req_valid_s1;
	opcode_t    opcode_s1;
	level_t     level_s1;
	logic       res_valid_s2;
	drive_t     drive_s2;
	min_lvl_t   min_start_q;
	delay_t     boost_delay_q;
	logic       advance;
	drive_t     drive_next;

	assign advance   = req_valid_s1 && (!res_valid_s2 || res.ready);
	assign cmd.ready = !req_valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_start_q   <= MIN_W'(MIN_START_RST);
			boost_delay_q <= DELAY_W'(BOOST_DELAY_RST);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MIN_START:   min_start_q   <= cfg.data[MIN_W-1:0];
				REG_BOOST_DELAY: boost_delay_q <= cfg.data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// Request register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			req_valid_s1 <= 1'b1;
		end else if (advance) begin
			req_valid_s1 <= 1'b0;
		end
	end

	// Request register payload
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			opcode_s1 <= cmd.opcode;
			level_s1  <= cmd.level;
		end
	end

	mdks_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.opcode      (opcode_s1),
		.level       (level_s1),
		.min_start   (min_start_q),
		.boost_delay (boost_delay_q),
		.drive_next  (drive_next)
	);

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (res.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2 <= drive_next;
		end
	end

	assign res.valid         = res_valid_s2;
	assign res.duty          = drive_s2.duty;
	assign res.drive_forward = drive_s2.drive_forward;
	assign res.drive_reverse = drive_s2.drive_reverse;
	assign res.kicking       = drive_s2.kicking;

endmodule

// File: test/mdks_drive_checker.sv
// Checker for the motor drive kick-start block: tracks drive state per request and compares results.
module mdks_drive_checker (
	input  logic        clk,
	input  logic        arst_n,
	mdks_cmd_if         cmd,
	mdks_res_if         res,
	mdks_cfg_if         cfg,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import mdks_pkg::*;

	// Register copies
	min_lvl_t min_start;
	delay_t   boost_delay;

	// Drive state
	logic     stalled;
	level_t   held_level;
	delay_t   boost_left;
	logic     boosting;
	duty_t    cur_duty;
	dir_t     cur_dir;

	drive_t      expected_drive[$];
	drive_t      want_drive;
	int unsigned mismatches = 0;

	assign fail_count = mismatches;

	// Apply a level to the bridge, starting a kick when a stalled motor gets too little
	function automatic void apply_level(level_t lv);
		int          lvi;
		int unsigned mag;
		int unsigned d;
		lvi = int'(lv);
		if (lvi == 0) begin
			cur_duty   = '0;
			cur_dir    = DIR_OFF;
			stalled    = 1'b1;
			boosting   = 1'b0;
			boost_left = '0;
			return;
		end
		mag = (lvi < 0) ? int'(-lvi) : lvi;
		if (mag > LEVEL_FULL)
			mag = LEVEL_FULL;
		if (stalled && mag < min_start) begin
			held_level = lv;
			mag        = (min_start > LEVEL_FULL) ? LEVEL_FULL : min_start;
			stalled    = 1'b0;
			boosting   = 1'b1;
			boost_left = (boost_delay == '0) ? delay_t'(1) : boost_delay;
		end
		d = (mag * DUTY_MAX) / LEVEL_FULL;
		if (d > DUTY_SAT)
			d = DUTY_SAT;
		cur_duty = duty_t'(d);
		cur_dir  = (lvi > 0) ? DIR_FWD : DIR_REV;
	endfunction

	// Advance the drive state by one request and return the drive it reports
	function automatic drive_t next_drive(opcode_t op, level_t lv);
		drive_t r;
		if (op == OP_SET_LEVEL) begin
			boosting   = 1'b0;
			boost_left = '0;
			apply_level(lv);
		end else if (boosting) begin
			boost_left = boost_left - 1'b1;
			if (boost_left == '0) begin
				boosting = 1'b0;
				apply_level(held_level);
			end
		end
		r.duty          = cur_duty;
		r.drive_forward = cur_dir[0];
		r.drive_reverse = cur_dir[1];
		r.kicking       = boosting;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Follow register writes, requests and results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_start   = min_lvl_t'(MIN_START_RST);
			boost_delay = delay_t'(BOOST_DELAY_RST);
			stalled     = 1'b1;
			held_level  = '0;
			boost_left  = '0;
			boosting    = 1'b0;
			cur_duty    = '0;
			cur_dir     = DIR_OFF;
			expected_drive.delete();
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MIN_START: begin
						min_start = cfg.data[MIN_W-1:0];
					end
					REG_BOOST_DELAY: begin
						boost_delay = cfg.data[DELAY_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.valid && cmd.ready)
				expected_drive.push_back(next_drive(cmd.opcode, cmd.level));
			if (res.valid && res.ready) begin
				if (expected_drive.size() == 0) begin
					$display("%0t: unexpected result, duty %0d fwd %0b rev %0b kick %0b",
						$time, res.duty, res.drive_forward, res.drive_reverse, res.kicking);
					mismatches++;
				end else begin
					want_drive = expected_drive.pop_front();
					check_field("duty", want_drive.duty, res.duty);
					check_field("drive_forward", want_drive.drive_forward, res.drive_forward);
					check_field("drive_reverse", want_drive.drive_reverse, res.drive_reverse);
					check_field("kicking", want_drive.kicking, res.kicking);
				end
			end
			outstanding <= expected_drive.size();
		end
	end

endmodule

// File: test/tb_motor_drive_kick_start_top.sv
// Testbench top of the motor drive kick-start block: clock, reset, stimulus and verdict.
module tb_motor_drive_kick_start_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mdks_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 175;
	localparam int unsigned LONG_HOLD   = 300;
	localparam int unsigned SETTLE      = 8;

	typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned cycles = 0;
	int unsigned hold_asks = 0;
	int unsigned burst_left = 0;
	int unsigned cfg_min = MIN_START_RST;

	mdks_cmd_if cmd ();
	mdks_res_if res ();
	mdks_cfg_if cfg ();

	motor_drive_kick_start_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res),
		.cfg    (cfg)
	);

	mdks_drive_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.res         (res),
		.cfg         (cfg),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	// Drop the run if it overstays its limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stall the result side on a pattern of its own, with a long hold when asked
	initial begin
		int unsigned seen;
		int unsigned window;
		int unsigned hold_left;
		rx_mode_t    mode;
		seen      = 0;
		window    = 0;
		hold_left = 0;
		mode      = RX_OPEN;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != seen) begin
				seen      = hold_asks;
				hold_left = LONG_HOLD;
			end
			if (window == 0) begin
				mode   = rx_mode_t'($urandom_range(0, 3));
				window = $urandom_range(8, 80);
			end
			window--;
			if (hold_left != 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				case (mode)
					RX_OPEN:   res.ready <= 1'b1;
					RX_HALF:   res.ready <= ($urandom_range(0, 1) == 1);
					RX_SPARSE: res.ready <= ($urandom_range(0, 3) == 0);
					default:   res.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Offer one request in bursts with random gaps, and hold it until accepted
	task automatic put_request(opcode_t op, level_t lv);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				cmd.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		cmd.valid  <= 1'b1;
		cmd.opcode <= op;
		cmd.level  <= lv;
		do @(posedge clk); while (!cmd.ready);
	endtask

	// Hold requests until every result is back, then let the pipeline settle
	task automatic drain();
		cmd.valid  <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// Write both registers on an idle block; junk in the unused upper bits of the minimum
	task automatic set_config(int unsigned min_lvl, int unsigned delay_val);
		cfg_data_t junk;
		drain();
		junk = cfg_data_t'($urandom_range(0, 63)) << MIN_W;
		write_reg(REG_MIN_START, junk | cfg_data_t'(min_lvl));
		write_reg(REG_BOOST_DELAY, cfg_data_t'(delay_val));
		cfg.valid <= 1'b0;
		cfg_min = min_lvl;
	endtask

	// Mix of ticks, stops and kick-provoking small levels with random content
	task automatic random_request();
		int unsigned pick;
		int unsigned mag;
		int unsigned top_mag;
		level_t      lv;
		pick = $urandom_range(0, 99);
		lv   = level_t'($urandom_range(0, 2047));
		if (pick < 40) begin
			put_request(OP_TICK, lv);
		end else if (pick < 52) begin
			put_request(OP_SET_LEVEL, '0);
		end else if (pick < 82) begin
			top_mag = (cfg_min + 40 > 1023) ? 1023 : cfg_min + 40;
			mag     = $urandom_range(1, top_mag);
			lv      = ($urandom_range(0, 1) == 1) ? level_t'(-int'(mag)) : level_t'(mag);
			put_request(OP_SET_LEVEL, lv);
		end else begin
			put_request(OP_SET_LEVEL, lv);
		end
	endtask

	initial begin
		int unsigned new_min;
		int unsigned new_delay;
		arst_n     = 1'b0;
		cmd.valid  = 1'b0;
		cmd.opcode = OP_SET_LEVEL;
		cmd.level  = '0;
		cfg.valid  = 1'b0;
		cfg.index  = REG_MIN_START;
		cfg.data   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: idle tick, kick, cancel by a new command, clamps, stop
		put_request(OP_TICK, level_t'($urandom_range(0, 2047)));
		put_request(OP_SET_LEVEL, level_t'(100));
		put_request(OP_TICK, '0);
		put_request(OP_SET_LEVEL, level_t'(-500));
		put_request(OP_SET_LEVEL, level_t'(1023));
		put_request(OP_SET_LEVEL, level_t'(-1024));
		put_request(OP_SET_LEVEL, '0);
		// Stalled flag survives a strong start, then a weak one kicks
		put_request(OP_SET_LEVEL, level_t'(600));
		put_request(OP_SET_LEVEL, level_t'(-1));
		put_request(OP_SET_LEVEL, '0);

		// Minimum above full scale and a zero delay
		set_config(1023, 0);
		put_request(OP_SET_LEVEL, level_t'(5));
		put_request(OP_TICK, '1);
		put_request(OP_TICK, '0);
		put_request(OP_SET_LEVEL, '0);
		put_request(OP_SET_LEVEL, level_t'(-1000));
		put_request(OP_TICK, '0);

		// Kick at full scale, expiry after three ticks
		set_config(1000, 3);
		put_request(OP_SET_LEVEL, '0);
		put_request(OP_SET_LEVEL, level_t'(999));
		repeat (3) put_request(OP_TICK, level_t'($urandom_range(0, 2047)));
		put_request(OP_SET_LEVEL, level_t'(1000));

		// Random phases over a spread of settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin new_min = 0;    new_delay = 1;     end
				1: begin new_min = 1023; new_delay = 0;     end
				2: begin new_min = 1000; new_delay = 65535; end
				3: begin new_min = $urandom_range(0, 1023); new_delay = $urandom_range(1, 20); end
				4: begin new_min = MIN_START_RST; new_delay = BOOST_DELAY_RST; end
				5: begin new_min = $urandom_range(0, 1023); new_delay = 2; end
				6: begin new_min = 1; new_delay = $urandom_range(1, 8); end
				default: begin
					new_min   = $urandom_range(0, 1023);
					new_delay = $urandom_range(0, 12);
				end
			endcase
			set_config(new_min, new_delay);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Fill the block against a long result stall
				if ((p == 3 || p == 6) && i == 40)
					hold_asks <= hold_asks + 1;
				// Pause the sender until every result is back
				if (p == 3 && i == 110)
					drain();
				random_request();
			end
		end

		drain();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
